// ===== design/osf_pkg.sv =====
// Shared constants, types and helpers for the odometry sensor fusion step.
`timescale 1ns / 1ps

package osf_pkg;

   // Pipeline shape
   localparam int STAGES     = 9;
   localparam int DIV_STAGES = 5;

   // Default ring depth of the accel moving average
   localparam int WINDOW_DEPTH_DEF = 16;

   // Divisors and biases of the rounded divisions (ties toward plus infinity)
   localparam int VEL_DIVISOR  = 4000;
   localparam int VEL_BIAS     = 2000;
   localparam int HEAD_DIVISOR = 2000;
   localparam int HEAD_BIAS    = 1000;

   // pi/180 in Q0.32
   localparam logic signed [27:0] PI_OVER_180_Q32 = 28'sd74961321;
   // Rounding offset for the Q0.32 product: 2^31
   localparam logic signed [60:0] YAW_ROUND = 61'sd2147483648;

   // Battery low-pass coefficients in Q0.16 (0.95 and 0.05)
   localparam logic [15:0] BAT_OLD_COEF = 16'd62259;
   localparam logic [11:0] BAT_NEW_COEF = 12'd3277;
   localparam logic [15:0] BAT_ROUND    = 16'd32768;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Per-stage load strobes plus the channel handshake outputs
   typedef struct packed {
      logic [STAGES:1] adv;
      logic            in_ready;
      logic            out_valid;
   } flow_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] value);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'(S32_MAX);
      lo = 64'(S32_MIN);
      if (value > hi) begin
         return S32_MAX;
      end else if (value < lo) begin
         return S32_MIN;
      end else begin
         return value[31:0];
      end
   endfunction

endpackage

// ===== design/odometry_sensor_fusion_step.sv =====
// Top level of the odometry sensor fusion step: accel mean, velocity, distance, yaw, heading, battery.
`timescale 1ns / 1ps
// A req transaction loads stage 1 on its accepting edge; rsp_valid is high once it loads the result stage.
// Throughput: one transaction per cycle unless rsp_ready stalls; the distance, battery
//   and heading integrators each close within their own stage, and the accel ring has one read and one write port.
// Stalls on rsp_ready only back up as far as the pipeline has no bubbles.
// Reset (synchronous, active high) empties the pipeline, clears the window's fill flags,
//   zeroes the sums and integrators, and clears mm_per_pulse; the window needs no clearing pass.

module odometry_sensor_fusion_step #(
   parameter int WINDOW_DEPTH = osf_pkg::WINDOW_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_accel_sample,
   input  logic signed [31:0] req_right_wheel_speed,
   input  logic signed [31:0] req_left_wheel_speed,
   input  logic signed [15:0] req_right_pulse_delta,
   input  logic signed [15:0] req_left_pulse_delta,
   input  logic signed [31:0] req_gyro_rate_dps,
   input  logic [30:0]        req_battery_sample,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_accel_mean,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_distance,
   output logic signed [31:0] rsp_yaw_rate,
   output logic signed [31:0] rsp_heading,
   output logic [30:0]        rsp_battery_filtered,

   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   localparam int NS        = osf_pkg::STAGES;
   localparam int SUM_WIDTH = 32 + $clog2(WINDOW_DEPTH);
   localparam int MEAN_NW   = SUM_WIDTH + 2;
   localparam int HEAD_NW   = 34;

   // Stage map: 1 capture, 2 window sum and products, 3 integrators and yaw,
   // 3..7 mean/velocity division, 4..8 heading division, 8 saturate, 9 result.
   localparam int MV_DIV_FIRST = 3;
   localparam int MV_DIV_LAST  = MV_DIV_FIRST + osf_pkg::DIV_STAGES - 1;
   localparam int HD_DIV_FIRST = 4;
   localparam int HD_DIV_LAST  = HD_DIV_FIRST + osf_pkg::DIV_STAGES - 1;

   osf_pkg::flow_type flow;

   logic [15:0] mm_ff;

   // stage 1
   logic signed [33:0] whl_sum;
   logic signed [32:0] whl_ff [1:MV_DIV_LAST];
   logic signed [16:0] pdiff_ff;
   logic signed [31:0] gyro_ff;
   logic [30:0]        bat_ff;

   // stage 2
   logic signed [SUM_WIDTH-1:0] win_sum;
   logic signed [32:0]          pmm_ff;
   logic signed [58:0]          yprod_ff;
   logic [42:0]                 bterm_ff;

   // stage 3 state and carried results
   logic signed [31:0] dist_total_ff;
   logic signed [31:0] dist_total_in;
   logic [30:0]        bat_level_ff;
   logic [30:0]        bat_level_in;
   logic [47:0]        bat_acc;
   logic signed [60:0] yaw_t;
   logic signed [31:0] yaw_in;
   logic signed [31:0] yaw_ff  [3:NS];
   logic signed [31:0] dist_ff [4:NS];
   logic [30:0]        batf_ff [4:NS];

   // divisions
   logic signed [MEAN_NW-1:0] mean_num;
   logic signed [MEAN_NW-1:0] vel_num;
   logic signed [MEAN_NW-1:0] mean_q;
   logic signed [MEAN_NW-1:0] vel_q;
   logic signed [HEAD_NW-1:0] head_num;
   logic signed [HEAD_NW-1:0] head_q;

   // stages 8 and 9
   logic signed [31:0] mean8_ff;
   logic signed [31:0] vel8_ff;
   logic signed [31:0] mean9_ff;
   logic signed [31:0] vel9_ff;
   logic signed [31:0] heading_total_ff;
   logic signed [31:0] heading_total_in;

   osf_flow_ctrl u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_ready (rsp_ready),
      .flow      (flow)
   );

   // config register; to be written only while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_ff <= '0;
      end else if (csr_wr_en) begin
         mm_ff <= csr_wr_data;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: capture the transaction. Wheel term is round((right - left) / 2),
   // which with ties toward plus infinity is (d + 1) >>> 1.
   // -------------------------------------------------------------------------
   assign whl_sum = 34'(req_right_wheel_speed) - 34'(req_left_wheel_speed) + 34'sd1;

   always_ff @(posedge clock) begin
      if (flow.adv[1]) begin
         whl_ff[1] <= whl_sum[33:1];
         pdiff_ff  <= 17'(req_right_pulse_delta) - 17'(req_left_pulse_delta);
         gyro_ff   <= req_gyro_rate_dps;
         bat_ff    <= req_battery_sample;
      end
      for (int k = 2; k <= MV_DIV_LAST; k++) begin
         if (flow.adv[k]) begin
            whl_ff[k] <= whl_ff[k-1];
         end
      end
   end

   // Ring read happens when stage 1 loads; the sum closes when stage 2 loads
   osf_accel_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SUM_WIDTH    (SUM_WIDTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .load         (flow.adv[1]),
      .commit       (flow.adv[2]),
      .accel_sample (req_accel_sample),
      .window_sum   (win_sum)
   );

   // -------------------------------------------------------------------------
   // Stage 2: one product per path, each registered before use
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (flow.adv[2]) begin
         pmm_ff   <= pdiff_ff * $signed({1'b0, mm_ff});
         yprod_ff <= gyro_ff * osf_pkg::PI_OVER_180_Q32;
         bterm_ff <= 43'(bat_ff) * 43'(osf_pkg::BAT_NEW_COEF) + 43'(osf_pkg::BAT_ROUND);
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: distance and battery integrators close here; yaw is the rounded
   // Q0.32 product, negated: floor((2^31 - gyro * pi/180) / 2^32). It never
   // reaches the 32 bit limits, so it needs no clamp.
   // -------------------------------------------------------------------------
   always_comb begin
      dist_total_in = osf_pkg::sat32(64'(dist_total_ff) + 64'(pmm_ff));
      bat_acc       = 48'(bat_level_ff) * 48'(osf_pkg::BAT_OLD_COEF) + 48'(bterm_ff);
      bat_level_in  = bat_acc[46:16];
      yaw_t         = osf_pkg::YAW_ROUND - 61'(yprod_ff);
      yaw_in        = {{3{yaw_t[60]}}, yaw_t[60:32]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_total_ff <= '0;
         bat_level_ff  <= '0;
      end else if (flow.adv[3]) begin
         dist_total_ff <= dist_total_in;
         bat_level_ff  <= bat_level_in;
      end
   end

   // carry yaw, distance and battery down to the result stage
   always_ff @(posedge clock) begin
      if (flow.adv[3]) begin
         yaw_ff[3] <= yaw_in;
      end
      if (flow.adv[4]) begin
         yaw_ff[4]  <= yaw_ff[3];
         dist_ff[4] <= dist_total_ff;
         batf_ff[4] <= bat_level_ff;
      end
      for (int k = 5; k <= NS; k++) begin
         if (flow.adv[k]) begin
            yaw_ff[k]  <= yaw_ff[k-1];
            dist_ff[k] <= dist_ff[k-1];
            batf_ff[k] <= batf_ff[k-1];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Rounded divisions: round(n / d) = floor((2n + d) / 2d)
   // -------------------------------------------------------------------------
   assign mean_num = {win_sum[SUM_WIDTH-1], win_sum, 1'b0} + MEAN_NW'(WINDOW_DEPTH);
   assign vel_num  = {win_sum[SUM_WIDTH-1], win_sum, 1'b0} + MEAN_NW'(osf_pkg::VEL_BIAS);
   assign head_num = {yaw_ff[3][31], yaw_ff[3], 1'b0} + HEAD_NW'(osf_pkg::HEAD_BIAS);

   osf_floor_div #(
      .DIVISOR (2 * WINDOW_DEPTH),
      .NW      (MEAN_NW)
   ) u_mean_div (
      .clock (clock),
      .adv   (flow.adv[MV_DIV_LAST:MV_DIV_FIRST]),
      .num   (mean_num),
      .quot  (mean_q)
   );

   osf_floor_div #(
      .DIVISOR (osf_pkg::VEL_DIVISOR),
      .NW      (MEAN_NW)
   ) u_vel_div (
      .clock (clock),
      .adv   (flow.adv[MV_DIV_LAST:MV_DIV_FIRST]),
      .num   (vel_num),
      .quot  (vel_q)
   );

   osf_floor_div #(
      .DIVISOR (osf_pkg::HEAD_DIVISOR),
      .NW      (HEAD_NW)
   ) u_head_div (
      .clock (clock),
      .adv   (flow.adv[HD_DIV_LAST:HD_DIV_FIRST]),
      .num   (head_num),
      .quot  (head_q)
   );

   // -------------------------------------------------------------------------
   // Stage 8: clamp mean and fused velocity
   // Stage 9: heading integrator closes here and the result register loads
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (flow.adv[8]) begin
         mean8_ff <= osf_pkg::sat32(64'(mean_q));
         vel8_ff  <= osf_pkg::sat32(64'(vel_q) + 64'(whl_ff[MV_DIV_LAST]));
      end
      if (flow.adv[NS]) begin
         mean9_ff <= mean8_ff;
         vel9_ff  <= vel8_ff;
      end
   end

   assign heading_total_in = osf_pkg::sat32(64'(heading_total_ff) + 64'(head_q));

   // heading total doubles as the result register for the heading field
   always_ff @(posedge clock) begin
      if (reset) begin
         heading_total_ff <= '0;
      end else if (flow.adv[NS]) begin
         heading_total_ff <= heading_total_in;
      end
   end

   assign req_ready            = flow.in_ready;
   assign rsp_valid            = flow.out_valid;
   assign rsp_accel_mean       = mean9_ff;
   assign rsp_velocity         = vel9_ff;
   assign rsp_distance         = dist_ff[NS];
   assign rsp_yaw_rate         = yaw_ff[NS];
   assign rsp_heading          = heading_total_ff;
   assign rsp_battery_filtered = batf_ff[NS];

endmodule

// ===== design/osf_flow_ctrl.sv =====
// Elastic valid/ready control for the fixed-depth result pipeline.
`timescale 1ns / 1ps

module osf_flow_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic              out_ready,
   output osf_pkg::flow_type flow
);

   localparam int NS = osf_pkg::STAGES;

   logic [NS:1] valid_ff;
   logic [NS:1] valid_in;
   logic [NS:1] take;
   logic [NS:1] adv;
   logic [NS:1] leave;

   // A stage can load when it is empty or its contents move on this cycle
   always_comb begin
      take[NS] = !valid_ff[NS] || out_ready;
      adv[NS]  = valid_ff[NS-1] && take[NS];
      for (int k = NS - 1; k >= 2; k--) begin
         take[k] = !valid_ff[k] || adv[k+1];
         adv[k]  = valid_ff[k-1] && take[k];
      end
      take[1] = !valid_ff[1] || adv[2];
      adv[1]  = in_valid && take[1];
   end

   always_comb begin
      for (int k = 1; k < NS; k++) begin
         leave[k] = adv[k+1];
      end
      leave[NS] = valid_ff[NS] && out_ready;
      valid_in  = adv | (valid_ff & ~leave);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign flow.adv       = adv;
   assign flow.in_ready  = take[1];
   assign flow.out_valid = valid_ff[NS];

endmodule

// ===== design/osf_floor_div.sv =====
// Pipelined signed floor division by a constant, reciprocal multiply with one correction.
`timescale 1ns / 1ps

module osf_floor_div #(
   parameter int DIVISOR = 2,
   parameter int NW      = 34
) (
   input  logic                            clock,
   input  logic [osf_pkg::DIV_STAGES:1]    adv,
   input  logic signed [NW-1:0]            num,
   output logic signed [NW-1:0]            quot
);

   localparam int UW = NW;
   localparam int HW = (UW + 1) / 2;
   localparam int PW = 2 * HW;

   localparam logic [UW:0]    TWO_POW = {1'b1, {UW{1'b0}}};
   localparam logic [UW:0]    RECIP   = TWO_POW / (UW + 1)'(DIVISOR);
   localparam logic [PW-1:0]  RECIP_P = PW'(RECIP);
   localparam logic [HW-1:0]  K_LO    = RECIP_P[HW-1:0];
   localparam logic [HW-1:0]  K_HI    = RECIP_P[PW-1:HW];
   localparam logic [UW-1:0]  DIV_U   = UW'(DIVISOR);
   localparam logic [UW-1:0]  DIV_M1  = UW'(DIVISOR - 1);

   // stage 1: magnitude, biased so that a negative dividend rounds toward minus infinity
   logic          neg1_ff;
   logic [UW-1:0] u1_ff;
   logic [UW-1:0] mag;
   logic [UW-1:0] u1_in;

   // stage 2: partial products
   logic          neg2_ff;
   logic [UW-1:0] u2_ff;
   logic [PW-1:0] u_pad;
   logic [PW-1:0] pp_hh_ff, pp_hl_ff, pp_lh_ff, pp_ll_ff;

   // stage 3: estimate, never above the true quotient and at most one below
   logic            neg3_ff;
   logic [UW-1:0]   u3_ff;
   logic [2*PW-1:0] prod;
   logic [UW-1:0]   q0_ff;

   // stage 4: corrected magnitude
   logic          neg4_ff;
   logic [UW-1:0] rem;
   logic [UW-1:0] q4_in;
   logic [UW-1:0] q4_ff;

   // stage 5: signed quotient
   logic signed [NW-1:0] quot_ff;

   always_comb begin
      mag   = ~num + UW'(1);
      u1_in = num[NW-1] ? (mag + DIV_M1) : num;
   end

   assign u_pad = PW'(u1_ff);

   always_comb begin
      prod = ((2 * PW)'(pp_hh_ff) << (2 * HW))
           + ((2 * PW)'(pp_hl_ff) << HW)
           + ((2 * PW)'(pp_lh_ff) << HW)
           + (2 * PW)'(pp_ll_ff);
   end

   always_comb begin
      rem   = u3_ff - q0_ff * DIV_U;
      q4_in = (rem >= DIV_U) ? (q0_ff + UW'(1)) : q0_ff;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         neg1_ff <= num[NW-1];
         u1_ff   <= u1_in;
      end
      if (adv[2]) begin
         neg2_ff  <= neg1_ff;
         u2_ff    <= u1_ff;
         pp_hh_ff <= u_pad[PW-1:HW] * K_HI;
         pp_hl_ff <= u_pad[PW-1:HW] * K_LO;
         pp_lh_ff <= u_pad[HW-1:0] * K_HI;
         pp_ll_ff <= u_pad[HW-1:0] * K_LO;
      end
      if (adv[3]) begin
         neg3_ff <= neg2_ff;
         u3_ff   <= u2_ff;
         q0_ff   <= prod[2*UW-1:UW];
      end
      if (adv[4]) begin
         neg4_ff <= neg3_ff;
         q4_ff   <= q4_in;
      end
      if (adv[5]) begin
         quot_ff <= neg4_ff ? -$signed(q4_ff) : $signed(q4_ff);
      end
   end

   assign quot = quot_ff;

endmodule

// ===== design/osf_accel_window.sv =====
// Ring of negated accel samples with a running sum.
`timescale 1ns / 1ps

module osf_accel_window #(
   parameter int WINDOW_DEPTH = osf_pkg::WINDOW_DEPTH_DEF,
   parameter int SUM_WIDTH    = 36
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic                        commit,
   input  logic signed [31:0]          accel_sample,
   output logic signed [SUM_WIDTH-1:0] window_sum
);

   localparam int PW = $clog2(WINDOW_DEPTH);

   logic signed [31:0]    mem [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] filled_ff;

   logic [PW-1:0]          pos_ff;
   logic [PW-1:0]          pos_in;
   logic [PW-1:0]          wr_pos_ff;
   logic signed [31:0]     rd_ff;
   logic                   rd_filled_ff;
   logic signed [31:0]     neg_ff;
   logic signed [31:0]     neg_in;
   logic signed [31:0]     old;
   logic signed [SUM_WIDTH-1:0] sum_ff;
   logic signed [SUM_WIDTH-1:0] sum_in;

   always_comb begin
      neg_in = (accel_sample == osf_pkg::S32_MIN) ? osf_pkg::S32_MAX : -accel_sample;
      pos_in = (pos_ff == PW'(WINDOW_DEPTH - 1)) ? '0 : pos_ff + PW'(1);
      old    = rd_filled_ff ? rd_ff : '0;
      sum_in = sum_ff - SUM_WIDTH'(old) + SUM_WIDTH'(neg_ff);
   end

   // read the retiring sample on load, write the new one on commit
   always_ff @(posedge clock) begin
      if (load) begin
         rd_ff     <= mem[pos_ff];
         wr_pos_ff <= pos_ff;
         neg_ff    <= neg_in;
      end
      if (commit) begin
         mem[wr_pos_ff] <= neg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         filled_ff    <= '0;
         rd_filled_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         if (load) begin
            pos_ff       <= pos_in;
            rd_filled_ff <= filled_ff[pos_ff];
         end
         if (commit) begin
            filled_ff[wr_pos_ff] <= 1'b1;
            sum_ff               <= sum_in;
         end
      end
   end

   assign window_sum = sum_ff;

endmodule

// ===== tb/sv/odometry_sensor_fusion_step_test.sv =====
// Self-checking testbench for the odometry sensor fusion step, with a built-in predictor.
`timescale 1ns / 1ps

module odometry_sensor_fusion_step_test;

   localparam int     RING_DEPTH     = osf_pkg::WINDOW_DEPTH_DEF;
   localparam int     DRAIN_CYCLES   = osf_pkg::STAGES + 4;
   localparam int     RANDOM_PHASES  = 5;
   localparam int     TICKS_PER_PHASE = 386;

   // Q0.32 pi/180 and the Q32 unit for the yaw rate conversion
   localparam longint DEG_TO_RAD_Q32 = 64'sd74961321;
   localparam longint Q32_ONE        = 64'sh1_0000_0000;
   localparam longint S32_TOP        = 64'sh0000_0000_7FFF_FFFF;
   localparam longint S32_BOTTOM     = -64'sh0000_0000_8000_0000;

   // Battery low-pass weights in Q0.16 (0.95 old, 0.05 new) plus rounding
   localparam longint unsigned BATT_KEEP     = 64'd62259;
   localparam longint unsigned BATT_TAKE     = 64'd3277;
   localparam longint unsigned BATT_ROUNDING = 64'd32768;

   typedef struct {
      logic signed [31:0] accel;
      logic signed [31:0] right_speed;
      logic signed [31:0] left_speed;
      logic signed [15:0] right_pulses;
      logic signed [15:0] left_pulses;
      logic signed [31:0] gyro;
      logic [30:0]        battery;
   } sensor_tick_t;

   typedef struct {
      logic signed [31:0] accel_mean;
      logic signed [31:0] velocity;
      logic signed [31:0] distance;
      logic signed [31:0] yaw_rate;
      logic signed [31:0] heading;
      logic [30:0]        battery;
   } fusion_out_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               csr_wr_en = 1'b0;
   logic [15:0]        csr_wr_data = '0;
   logic signed [31:0] rsp_accel_mean;
   logic signed [31:0] rsp_velocity;
   logic signed [31:0] rsp_distance;
   logic signed [31:0] rsp_yaw_rate;
   logic signed [31:0] rsp_heading;
   logic [30:0]        rsp_battery_filtered;

   // Payload currently on the request channel
   sensor_tick_t req_item;

   // Traffic bookkeeping
   sensor_tick_t pending_ticks[$];
   fusion_out_t  expected_outputs[$];
   int unsigned  ticks_queued = 0;
   int unsigned  ticks_taken = 0;
   int unsigned  fail_count = 0;
   bit           req_fire = 1'b0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_gap = 0;
   int unsigned  req_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;

   // Predictor state: accel ring, odometry integrators, battery filter, register copy
   int           accel_ring[RING_DEPTH];
   longint       ring_sum;
   int           ring_slot;
   int           odo_distance;
   int           odo_heading;
   logic [30:0]  batt_level;
   logic [15:0]  cfg_mm_per_pulse;

   always #2 clock = ~clock;

   odometry_sensor_fusion_step dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_accel_sample     (req_item.accel),
      .req_right_wheel_speed(req_item.right_speed),
      .req_left_wheel_speed (req_item.left_speed),
      .req_right_pulse_delta(req_item.right_pulses),
      .req_left_pulse_delta (req_item.left_pulses),
      .req_gyro_rate_dps    (req_item.gyro),
      .req_battery_sample   (req_item.battery),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_accel_mean       (rsp_accel_mean),
      .rsp_velocity         (rsp_velocity),
      .rsp_distance         (rsp_distance),
      .rsp_yaw_rate         (rsp_yaw_rate),
      .rsp_heading          (rsp_heading),
      .rsp_battery_filtered (rsp_battery_filtered),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   // Floor division: round the truncated quotient down when signs differ and a remainder exists
   function automatic longint floor_quot(longint num, longint den);
      longint quot;
      quot = num / den;
      if ((num % den) != 0 && ((num < 0) != (den < 0))) begin
         quot = quot - 1;
      end
      return quot;
   endfunction

   // Round to nearest, ties toward plus infinity
   function automatic longint round_quot(longint num, longint den);
      return floor_quot(2 * num + den, 2 * den);
   endfunction

   function automatic longint clip32(longint value);
      if (value > S32_TOP) begin
         return S32_TOP;
      end else if (value < S32_BOTTOM) begin
         return S32_BOTTOM;
      end
      return value;
   endfunction

   // Advance the predictor by one control tick and return the fused outputs
   function automatic fusion_out_t fuse_tick(sensor_tick_t s);
      fusion_out_t        r;
      longint             neg_accel;
      longint             yaw;
      longint unsigned    batt_acc;
      // Negate accel with saturation, then swap it into the ring
      neg_accel = clip32(-longint'(s.accel));
      ring_sum = ring_sum - longint'(accel_ring[ring_slot]) + neg_accel;
      accel_ring[ring_slot] = int'(neg_accel);
      ring_slot = (ring_slot == RING_DEPTH - 1) ? 0 : ring_slot + 1;
      r.accel_mean = 32'(clip32(round_quot(ring_sum, RING_DEPTH)));
      r.velocity = 32'(clip32(round_quot(ring_sum, 2000) +
                   round_quot(longint'(s.right_speed) - longint'(s.left_speed), 2)));
      // Pulse difference times mm per pulse is already Q16.16
      odo_distance = int'(clip32(longint'(odo_distance) +
                     (longint'(s.right_pulses) - longint'(s.left_pulses)) *
                     longint'(cfg_mm_per_pulse)));
      r.distance = odo_distance;
      yaw = clip32(round_quot(-(longint'(s.gyro) * DEG_TO_RAD_Q32), Q32_ONE));
      r.yaw_rate = 32'(yaw);
      odo_heading = int'(clip32(longint'(odo_heading) + round_quot(yaw, 1000)));
      r.heading = odo_heading;
      batt_acc = BATT_KEEP * batt_level + BATT_TAKE * s.battery + BATT_ROUNDING;
      batt_level = batt_acc[46:16];
      r.battery = batt_level;
      return r;
   endfunction

   // Random signed value of the given width: extremes, small, scaled down or full range
   function automatic longint pick_signed(int unsigned width);
      int unsigned raw;
      longint      lim;
      longint      full;
      raw = $urandom;
      lim = longint'(1) << (width - 1);
      full = longint'($signed(raw)) >>> (32 - width);
      case ($urandom_range(7))
         0: return -lim;
         1: return lim - 1;
         2: return longint'($urandom_range(16)) - 8;
         3, 4: return full >>> $urandom_range(width - 1);
         default: return full;
      endcase
   endfunction

   function automatic longint pick_battery();
      longint full;
      full = longint'($urandom) >> 1;
      case ($urandom_range(7))
         0: return 64'h7FFF_FFFF;
         1: return 0;
         2, 3: return 64'(12 + $urandom_range(3)) << 16;
         default: return full >> $urandom_range(30);
      endcase
   endfunction

   task automatic queue_tick(input longint accel, input longint right_speed,
                             input longint left_speed, input longint right_pulses,
                             input longint left_pulses, input longint gyro,
                             input longint battery);
      sensor_tick_t s;
      s.accel = 32'(accel);
      s.right_speed = 32'(right_speed);
      s.left_speed = 32'(left_speed);
      s.right_pulses = 16'(right_pulses);
      s.left_pulses = 16'(left_pulses);
      s.gyro = 32'(gyro);
      s.battery = 31'(battery);
      pending_ticks.push_back(s);
      ticks_queued++;
   endtask

   // Write the register while the block is idle; the copy follows the write edge
   task automatic write_mm_per_pulse(input logic [15:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cfg_mm_per_pulse = value;
      @(posedge clock);
   endtask

   // Hold until every queued tick is taken and every result is back, then let the pipe settle
   task automatic drain_pipeline();
      while (ticks_taken != ticks_queued || expected_outputs.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string what, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Request driver: advance to the next tick once the current transaction is taken,
   // inserting idle bursts of random length
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
            req_gap = $urandom_range(7);
            req_valid <= 1'b0;
         end else begin
            req_item <= pending_ticks.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // Response back-pressure: drop ready in bursts of random length
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
         rsp_gap = $urandom_range(7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict on each accepted request, check each accepted response in order
   always @(posedge clock) begin
      fusion_out_t want;
      req_fire = !reset && ((req_valid && req_ready) === 1'b1);
      if (req_fire) begin
         expected_outputs.push_back(fuse_tick(req_item));
         ticks_taken++;
      end
      if (!reset && ((rsp_valid && rsp_ready) === 1'b1)) begin
         if (expected_outputs.size() == 0) begin
            fail_count++;
            $display("%0t ns: unexpected response transaction, expected none, actual mean %0d",
                     $time, rsp_accel_mean);
         end else begin
            want = expected_outputs.pop_front();
            check_field("accel_mean", want.accel_mean, rsp_accel_mean);
            check_field("velocity", want.velocity, rsp_velocity);
            check_field("distance", want.distance, rsp_distance);
            check_field("yaw_rate", want.yaw_rate, rsp_yaw_rate);
            check_field("heading", want.heading, rsp_heading);
            check_field("battery_filtered", longint'(want.battery),
                        longint'(rsp_battery_filtered));
         end
      end
   end

   // Stimulus sequence
   initial begin : run_sequence
      logic [15:0] mm_value;
      int          phase;
      int          n;
      req_item = '{default: '0};
      foreach (accel_ring[i]) begin
         accel_ring[i] = 0;
      end
      ring_sum = 0;
      ring_slot = 0;
      odo_distance = 0;
      odo_heading = 0;
      batt_level = '0;
      cfg_mm_per_pulse = '0;

      // Hold reset, then release it on a falling edge
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the largest scale so distance saturates both ways
      req_idle_pct = 10;
      rsp_stall_pct = 10;
      write_mm_per_pulse(16'hFFFF);
      queue_tick(0, 0, 0, 0, 0, 0, 0);
      // most negative accel saturates on negation; velocity overflows upward
      queue_tick(S32_BOTTOM, S32_TOP, S32_BOTTOM, 32767, -32768, S32_BOTTOM, 64'h7FFF_FFFF);
      // velocity falls to one above its lower limit without overflowing
      queue_tick(S32_TOP, S32_BOTTOM, S32_TOP, -32768, 32767, S32_TOP, 0);
      // rounding ties on the half wheel difference
      queue_tick(-1, 1, 0, 1, 0, 1, 1);
      queue_tick(1, 0, 1, 0, 1, -1, 12 << 16);
      // run the ring past its wrap with saturated samples
      for (n = 0; n < 17; n++) begin
         queue_tick(S32_BOTTOM, (n % 2) ? S32_TOP : S32_BOTTOM,
                    (n % 2) ? S32_BOTTOM : S32_TOP, (n % 2) ? 32767 : -32768,
                    (n % 3) ? 100 : -100, (n % 2) ? S32_TOP : S32_BOTTOM, 64'h7FFF_FFFF);
      end
      queue_tick(S32_TOP, 0, 0, 0, 0, 0, 64'h7FFF_FFFF);
      queue_tick(S32_TOP, 0, 0, 0, 0, 0, 64'h7FFF_FFFF);
      drain_pipeline();

      // Random phases, each at a new scale; the last one runs without idling
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               mm_value = 16'h0000;
               req_idle_pct = 15;
               rsp_stall_pct = 20;
            end
            1: begin
               mm_value = 16'($urandom);
               req_idle_pct = 0;
               rsp_stall_pct = 30;
            end
            2: begin
               mm_value = 16'h0001;
               req_idle_pct = 30;
               rsp_stall_pct = 0;
            end
            3: begin
               mm_value = 16'hFFFF;
               req_idle_pct = 8;
               rsp_stall_pct = 12;
            end
            default: begin
               mm_value = 16'($urandom_range(512, 1));
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         write_mm_per_pulse(mm_value);
         for (n = 0; n < TICKS_PER_PHASE; n++) begin
            queue_tick(pick_signed(32), pick_signed(32), pick_signed(32), pick_signed(16),
                       pick_signed(16), pick_signed(32), pick_battery());
         end
         drain_pipeline();
      end

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: fail and end the run if it is still going at the time limit
   initial begin : watchdog
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
design/osf_pkg.sv
design/osf_flow_ctrl.sv
design/osf_floor_div.sv
design/osf_accel_window.sv
design/odometry_sensor_fusion_step.sv
tb/sv/odometry_sensor_fusion_step_test.sv
